// ===== hw/rtl/lpfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the length-prefix frame decoder.
// Used by lpfd_ctrl and the top level; it depends on nothing else.

package lpfd_pkg;

	localparam int ACT_W        = 2;
	localparam int DATA_W       = 8;
	localparam int IDX_W        = 10;
	localparam int LEN_W        = 11;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int PREFIX_BYTES = 2;

	localparam int MAX_MESSAGE_DEF = 1024;

	localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(241);
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = CFG_IDX_W'(1);

	localparam logic [STATUS_W-1:0] ST_NEED_MORE = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_READY     = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_BAD_LEN   = STATUS_W'(2);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_CONSUME = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                byte_taken;
		logic [LEN_W-1:0]    message_length;
		logic                read_hit;
	} result_t;

endpackage

// ===== hw/rtl/lpfd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the payload store of the frame decoder.

module lpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/lpfd_ctrl.sv =====
`timescale 1ns / 1ps
// Frame tracking state of the decoder: fill count, prefix, ready length and malformed flag.
// Depends on lpfd_pkg; drives the write port of the payload RAM.

module lpfd_ctrl #(
	parameter int MAX_MESSAGE = lpfd_pkg::MAX_MESSAGE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  lpfd_pkg::action_t              action,
	input  logic [lpfd_pkg::DATA_W-1:0]    data_byte,
	input  logic [lpfd_pkg::IDX_W-1:0]     read_index,
	input  logic [lpfd_pkg::LEN_W-1:0]     min_length,
	input  logic [lpfd_pkg::LEN_W-1:0]     max_length,
	output logic                           wr_en,
	output logic [$clog2(MAX_MESSAGE)-1:0] wr_addr,
	output logic [lpfd_pkg::DATA_W-1:0]    wr_data,
	output lpfd_pkg::result_t              result
);

	import lpfd_pkg::*;

	localparam int StoreDepth = MAX_MESSAGE + PREFIX_BYTES;
	localparam int FW = $clog2(StoreDepth + 1);
	localparam int AW = $clog2(MAX_MESSAGE);
	localparam int CW = 18;
	localparam int PW = 2 * DATA_W;

	logic [FW-1:0]     fill_q, fill_d;
	logic [LEN_W-1:0]  ready_q, ready_d;
	logic              bad_q, bad_d;
	logic [DATA_W-1:0] pfx_hi_q, pfx_lo_q;
	logic              pfx_hi_we, pfx_lo_we;

	logic [CW-1:0] fill_ext, new_fill, len_ext, wanted, lo_bound, hi_bound;
	logic [PW-1:0] new_len;
	logic          is_ready, take, read_hit;

	always_comb begin
		fill_ext  = CW'(fill_q);
		new_fill  = fill_ext + CW'(1);
		len_ext   = CW'({pfx_hi_q, pfx_lo_q});
		wanted    = (fill_ext >= CW'(PREFIX_BYTES)) ? len_ext + CW'(PREFIX_BYTES)
			: CW'(PREFIX_BYTES);
		lo_bound  = (min_length == '0) ? CW'(1) : CW'(min_length);
		hi_bound  = (CW'(max_length) > CW'(MAX_MESSAGE)) ? CW'(MAX_MESSAGE) : CW'(max_length);
		is_ready  = (ready_q != '0);
		new_len   = (fill_q == FW'(1)) ? {pfx_hi_q, data_byte} : {pfx_hi_q, pfx_lo_q};
		fill_d    = fill_q;
		ready_d   = ready_q;
		bad_d     = bad_q;
		take      = 1'b0;
		read_hit  = 1'b0;
		pfx_hi_we = 1'b0;
		pfx_lo_we = 1'b0;
		wr_en     = 1'b0;
		unique case (action)
			ACT_PUSH: begin
				if (!bad_q && !is_ready && fill_ext < wanted && fill_ext < CW'(StoreDepth)) begin
					take      = 1'b1;
					fill_d    = FW'(new_fill);
					pfx_hi_we = (fill_q == FW'(0));
					pfx_lo_we = (fill_q == FW'(1));
					wr_en     = (fill_ext >= CW'(PREFIX_BYTES));
					if (new_fill >= CW'(PREFIX_BYTES)) begin
						if (CW'(new_len) < lo_bound || CW'(new_len) > hi_bound) begin
							bad_d = 1'b1;
						end else if (new_fill >= CW'(new_len) + CW'(PREFIX_BYTES)) begin
							ready_d = LEN_W'(new_len);
						end
					end
				end
			end
			ACT_READ: begin
				read_hit = !bad_q && is_ready && (CW'(read_index) < CW'(ready_q));
			end
			ACT_CONSUME: begin
				if (is_ready) begin
					fill_d  = '0;
					ready_d = '0;
					bad_d   = 1'b0;
				end
			end
			ACT_CLEAR: begin
				fill_d  = '0;
				ready_d = '0;
				bad_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = AW'(fill_ext - CW'(PREFIX_BYTES));
	assign wr_data = data_byte;

	always_comb begin
		result.byte_taken     = take;
		result.read_hit       = read_hit;
		result.status         = bad_d ? ST_BAD_LEN : ((ready_d != '0) ? ST_READY : ST_NEED_MORE);
		result.message_length = (!bad_d) ? ready_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ready_q <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			fill_q  <= fill_d;
			ready_q <= ready_d;
			bad_q   <= bad_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pfx_hi_we) begin
			pfx_hi_q <= data_byte;
		end
		if (accept && pfx_lo_we) begin
			pfx_lo_q <= data_byte;
		end
	end

	a_not_ready_and_bad: assert property (@(posedge clk) disable iff (!arst_n)
		!(bad_q && ready_q != '0))
		else $error("ready frame held while the malformed flag is set");

	a_fill_matches_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q != '0) |-> (CW'(fill_q) == CW'(ready_q) + CW'(PREFIX_BYTES)))
		else $error("fill count does not match the ready frame");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= CW'(StoreDepth))
		else $error("fill count ran past the store");

endmodule

// ===== hw/rtl/length_prefix_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the length-prefix frame decoder: config registers, result pipeline.
// Depends on lpfd_pkg, lpfd_ctrl and lpfd_ram.
//
// Usage: each input word carries an action (push, read, consume, clear) with a
// stream byte and a payload read offset. Every accepted word yields exactly one
// result word with status, byte_taken, message_length and read_byte.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. Configuration (min_length at index 0, max_length at index 1) is
// written through cfg_we, cfg_index and cfg_data; the user must do so only while no
// word is in flight, the block does not enforce this. Throughput is one word per
// cycle while in_stall is low: the state update happens in the cycle a word is
// accepted, and the payload RAM is read on its single read port only for read words.
// A result waiting at the output does not block input; a second result is held in
// the first stage, and only when both stages are full and the receiver stalls is
// in_stall raised. After reset the decoder is empty, not malformed, and the length
// bounds hold 241 and 1024; the payload RAM needs no clearing pass.

module length_prefix_frame_decoder #(
	parameter int MAX_MESSAGE = lpfd_pkg::MAX_MESSAGE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpfd_pkg::ACT_W-1:0]        action,
	input  logic [lpfd_pkg::DATA_W-1:0]       data_byte,
	input  logic [lpfd_pkg::IDX_W-1:0]        read_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lpfd_pkg::STATUS_W-1:0]     status,
	output logic                              byte_taken,
	output logic [lpfd_pkg::LEN_W-1:0]        message_length,
	output logic [lpfd_pkg::DATA_W-1:0]       read_byte,
	input  logic                              cfg_we,
	input  logic [lpfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpfd_pkg::LEN_W-1:0]        cfg_data
);

	import lpfd_pkg::*;

	localparam int AW = $clog2(MAX_MESSAGE);

	logic [LEN_W-1:0]  min_length_q, max_length_q;
	logic              in_acc, adv_s1;
	action_t           act;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	result_t           result;

	logic              valid_s1, valid_s2;
	result_t           res_s1;
	result_t           res_s2;
	logic [DATA_W-1:0] read_byte_s2;

	assign act      = action_t'(action);
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LENGTH: min_length_q <= cfg_data;
				REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lpfd_ctrl #(
		.MAX_MESSAGE(MAX_MESSAGE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.action    (act),
		.data_byte (data_byte),
		.read_index(read_index),
		.min_length(min_length_q),
		.max_length(max_length_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.result    (result)
	);

	lpfd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_MESSAGE)
	) u_store (
		.clk    (clk),
		.wr_en  (in_acc && wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (in_acc && act == ACT_READ),
		.rd_addr(AW'(read_index)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv_s1);
			valid_s2 <= adv_s1 || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= result;
		end
		if (adv_s1) begin
			res_s2       <= res_s1;
			read_byte_s2 <= res_s1.read_hit ? rd_data : '0;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign byte_taken     = res_s2.byte_taken;
	assign message_length = res_s2.message_length;
	assign read_byte      = read_byte_s2;

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(valid_s1 && !adv_s1))
		else $error("first stage overwritten while holding a word");

	a_length_only_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_READY) == (message_length != '0)))
		else $error("message length disagrees with status");

	a_read_only_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_byte != '0) |-> (status == ST_READY))
		else $error("payload byte returned outside a ready frame");

endmodule
